### design/bounded_deque_with_search_unit_macros.svh
// Assertion helpers used by the deque RTL.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_UNIT_MACROS_SVH

// Checked at every clock edge outside of reset.
`define BDQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define BDQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### design/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bdq_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int OPCODE_W       = 3;
   localparam int STATUS_W       = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SEARCH     = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      logic fire;
      logic push_front;
      logic pop_front;
      logic search;
   } cell_ctrl_type;

endpackage
`default_nettype wire

### design/bdq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module bdq_cell #(
   parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire bdq_pkg::cell_ctrl_type  ctrl,
   input  wire logic                    load_back,
   input  wire logic                    live,
   input  wire logic [DATA_WIDTH-1:0]   key,
   input  wire logic [DATA_WIDTH-1:0]   left_data,
   input  wire logic [DATA_WIDTH-1:0]   right_data,
   output logic      [DATA_WIDTH-1:0]   data_ff,
   output logic                         match_ff
);
   import bdq_pkg::*;

   logic [DATA_WIDTH-1:0] data_in;
   logic                  match_in;

   // A push at the front moves every entry one cell toward the back;
   // a pop at the front moves every entry one cell toward the front.
   always_comb begin
      if (ctrl.push_front) begin
         data_in = left_data;
      end else if (ctrl.pop_front) begin
         data_in = right_data;
      end else if (load_back) begin
         data_in = key;
      end else begin
         data_in = data_ff;
      end
      match_in = ctrl.search && live && (data_ff == key);
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (ctrl.fire) begin
         match_ff <= match_in;
      end
   end

endmodule
`default_nettype wire

### design/bounded_deque_with_search_unit.sv
// Channel | Direction | tdata fields, lowest bit first
// req_    | in        | opcode[2:0], value[DATA_WIDTH-1:0], zero pad to bytes
// rsp_    | out       | status[1:0], found, occupancy_after, zero pad to bytes
//
// One item is accepted per cycle while req_tready is high; each result passes the
// compare stage and then the output register. The row of cells shifts, loads and
// compares in the accepting cycle; per-cell match bits are ORed into the found bit.
// Reset clears the occupancy and the pipeline valid bits; cell contents are not reset.
// A stalled result holds the output register, and the intake stops only once the
// compare stage behind it is also occupied.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_deque_with_search_unit_macros.svh"
module bounded_deque_with_search_unit #(
   parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
   localparam int OCC_W     = $clog2(DEPTH + 1),
   localparam int REQ_W     = ((bdq_pkg::OPCODE_W + DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_W     = ((bdq_pkg::STATUS_W + 1 + OCC_W + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,  // opcode, value
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [RSP_W-1:0] rsp_tdata   // status, found, occupancy_after
);
   import bdq_pkg::*;

   opcode_type            opcode;
   logic [DATA_WIDTH-1:0] key;
   logic                  accept;
   logic                  advance;
   logic                  full;
   logic                  empty;
   logic                  push_back_ok;
   cell_ctrl_type         ctrl;

   logic [OCC_W-1:0]      occ_ff, occ_in;
   status_type            status_in;

   logic                  s1_valid_ff, s1_valid_in;
   status_type            s1_status_ff;
   logic [OCC_W-1:0]      s1_occ_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   logic                  rsp_found_ff;
   logic [OCC_W-1:0]      rsp_occ_ff;

   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]      cell_match;

   assign opcode  = opcode_type'(req_tdata[OPCODE_W-1:0]);
   assign key     = req_tdata[OPCODE_W +: DATA_WIDTH];
   assign advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign accept  = req_tvalid && req_tready;
   assign full    = (occ_ff == OCC_W'(DEPTH));
   assign empty   = (occ_ff == '0);

   always_comb begin
      status_in       = ST_OK;
      occ_in          = occ_ff;
      ctrl.fire       = accept;
      ctrl.push_front = 1'b0;
      ctrl.pop_front  = 1'b0;
      ctrl.search     = 1'b0;
      push_back_ok    = 1'b0;
      case (opcode)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               occ_in          = occ_ff + OCC_W'(1);
               ctrl.push_front = accept && (opcode == OP_PUSH_FRONT);
               push_back_ok    = accept && (opcode == OP_PUSH_BACK);
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               occ_in         = occ_ff - OCC_W'(1);
               ctrl.pop_front = accept && (opcode == OP_POP_FRONT);
            end
         end
         OP_SEARCH: begin
            ctrl.search = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Cell 0 holds the front entry; live entries fill cells 0 to occupancy-1.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = key;
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
      end
      bdq_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .load_back  (push_back_ok && (occ_ff == OCC_W'(i))),
         .live       (OCC_W'(i) < occ_ff),
         .key        (key),
         .left_data  (left_data),
         .right_data (right_data),
         .data_ff    (cell_data[i]),
         .match_ff   (cell_match[i])
      );
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            occ_ff <= occ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= status_in;
         s1_occ_ff    <= occ_in;
      end
      if (advance && s1_valid_ff) begin
         rsp_status_ff <= s1_status_ff;
         rsp_found_ff  <= |cell_match;
         rsp_occ_ff    <= s1_occ_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_occ_ff, rsp_found_ff, rsp_status_ff});

   // The occupancy is unknown until the first reset edge has been seen.
   `BDQ_ASSERT_ALWAYS(a_occ_bound,
      reset || occ_ff <= OCC_W'(DEPTH),
      "occupancy above depth")
   `BDQ_ASSERT(a_full_push_drops,
      accept && full && (opcode == OP_PUSH_BACK || opcode == OP_PUSH_FRONT)
         |=> occ_ff == OCC_W'(DEPTH),
      "push on full queue changed occupancy")
   `BDQ_ASSERT(a_empty_pop_holds,
      accept && empty && (opcode == OP_POP_FRONT || opcode == OP_POP_BACK)
         |=> occ_ff == '0,
      "pop on empty queue changed occupancy")
   `BDQ_ASSERT(a_found_ok,
      rsp_valid_ff && rsp_found_ff |-> rsp_status_ff == ST_OK && rsp_occ_ff != '0,
      "match reported with bad status or empty queue")
   `BDQ_ASSERT(a_stage_order,
      s1_valid_ff && !advance |-> !accept,
      "item taken over a stalled compare stage")

endmodule
`default_nettype wire

### test/bounded_deque_with_search_unit_test.sv
`timescale 1ns / 1ps
module bounded_deque_with_search_unit_test;
   import bdq_pkg::*;

   localparam int CAPACITY     = DEPTH_DEF;
   localparam int VALUE_W      = DATA_WIDTH_DEF;
   localparam int OCC_W        = $clog2(CAPACITY + 1);
   localparam int REQ_W        = ((OPCODE_W + VALUE_W + 7) / 8) * 8;
   localparam int RSP_W        = ((STATUS_W + 1 + OCC_W + 7) / 8) * 8;
   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 650;
   localparam int REPORT_LIMIT = 10;

   // Opcodes that the package leaves undefined; the block must treat them as no-ops.
   localparam logic [OPCODE_W-1:0] FIRST_SPARE_OP = 3'd5;
   localparam logic [OPCODE_W-1:0] LAST_SPARE_OP  = 3'd7;

   typedef enum int {
      MODE_FILL,
      MODE_DRAIN,
      MODE_MIXED
   } walk_mode_type;

   typedef struct {
      status_type         status;
      logic               found;
      logic [OCC_W-1:0]   occupancy;
   } deque_result_type;

   class deque_tracker_type;
      logic [VALUE_W-1:0] live_entries[$];
      deque_result_type   pending_results[$];
      int                 mismatches;

      function new();
         mismatches = 0;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // Returns a stored value so that searches can hit, or noise when empty.
      function logic [VALUE_W-1:0] stored_key();
         if (live_entries.size() == 0) begin
            return $urandom;
         end
         return live_entries[$urandom_range(0, live_entries.size() - 1)];
      endfunction

      function void note_request(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] key);
         deque_result_type want;
         want.status = ST_OK;
         want.found  = 1'b0;
         case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (live_entries.size() >= CAPACITY) begin
                  want.status = ST_FULL;
               end else if (op == OP_PUSH_FRONT) begin
                  live_entries.push_front(key);
               end else begin
                  live_entries.push_back(key);
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               if (live_entries.size() == 0) begin
                  want.status = ST_EMPTY;
               end else if (op == OP_POP_FRONT) begin
                  void'(live_entries.pop_front());
               end else begin
                  void'(live_entries.pop_back());
               end
            end
            OP_SEARCH: begin
               foreach (live_entries[i]) begin
                  if (live_entries[i] == key) begin
                     want.found = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
         want.occupancy = OCC_W'(live_entries.size());
         pending_results.push_back(want);
      endfunction

      function void check_result(logic [RSP_W-1:0] word);
         deque_result_type    want;
         logic [STATUS_W-1:0] got_status;
         logic               got_found;
         logic [OCC_W-1:0]   got_occ;
         got_status = word[STATUS_W-1:0];
         got_found  = word[STATUS_W];
         got_occ    = word[STATUS_W+1 +: OCC_W];
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("unexpected result: status %0d found %0d occupancy %0d",
                        got_status, got_found, got_occ);
            end
            return;
         end
         want = pending_results.pop_front();
         if (got_status !== want.status || got_found !== want.found ||
             got_occ !== want.occupancy) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("result mismatch: expected status %0d found %0d occupancy %0d, %s",
                        want.status, want.found, want.occupancy, "got");
               $display("   actual status %0d found %0d occupancy %0d",
                        got_status, got_found, got_occ);
            end
         end
      endfunction
   endclass

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   deque_tracker_type tracker = new();
   bit           calm_phase = 1'b0;
   int           idle_cycles = 0;
   int           rsp_stall_left = 0;

   bounded_deque_with_search_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one; none during a calm phase.
   function int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm_phase || roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end else if (roll < 98) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   function logic [VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
         endcase
      end else if (roll < 40) begin
         return $urandom_range(0, 7);
      end
      return $urandom;
   endfunction

   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] key);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - OPCODE_W - VALUE_W){1'b0}}, key, op};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic run_directed();
      send_item(OP_SEARCH, 32'h0000_0000);
      send_item(OP_POP_FRONT, 32'h1234_5678);
      send_item(OP_POP_BACK, 32'hFFFF_FFFF);
      send_item(OP_PUSH_FRONT, 32'h7FFF_FFFF);
      send_item(OP_PUSH_BACK, 32'h8000_0000);
      send_item(OP_PUSH_FRONT, 32'h0000_0000);
      send_item(OP_PUSH_BACK, 32'hFFFF_FFFF);
      send_item(OP_SEARCH, 32'h8000_0000);
      send_item(OP_SEARCH, 32'h7FFF_FFFF);
      send_item(OP_SEARCH, 32'h0000_0001);
      send_item(FIRST_SPARE_OP, 32'hFFFF_FFFF);
      send_item(FIRST_SPARE_OP + 3'd1, 32'h8000_0000);
      send_item(LAST_SPARE_OP, 32'h0000_0000);
      send_item(OP_POP_FRONT, 32'h0000_0000);
      send_item(OP_POP_BACK, 32'h0000_0000);
      send_item(OP_SEARCH, 32'hFFFF_FFFF);
      send_item(OP_SEARCH, 32'h7FFF_FFFF);
      send_item(OP_POP_FRONT, 32'h0000_0000);
      send_item(OP_POP_BACK, 32'h0000_0000);
      send_item(OP_POP_BACK, 32'h0000_0000);
   endtask

   // A biased walk, so that the deque is driven to full and back to empty repeatedly.
   task automatic run_random();
      walk_mode_type mode;
      int            sent;
      int            stretch;
      int            roll;
      int            push_cut;
      int            pop_cut;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mode       = walk_mode_type'($urandom_range(0, 2));
         calm_phase = ($urandom_range(0, 3) == 0);
         stretch    = $urandom_range(20, 60);
         case (mode)
            MODE_FILL:  begin push_cut = 65; pop_cut = 75; end
            MODE_DRAIN: begin push_cut = 15; pop_cut = 75; end
            default:    begin push_cut = 40; pop_cut = 75; end
         endcase
         repeat (stretch) begin
            roll = $urandom_range(0, 99);
            if (roll < push_cut) begin
               send_item($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
            end else if (roll < pop_cut) begin
               send_item($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, $urandom);
            end else if (roll < 97) begin
               send_item(OP_SEARCH,
                         $urandom_range(0, 1) ? tracker.stored_key() : pick_value());
            end else begin
               send_item(OPCODE_W'($urandom_range(FIRST_SPARE_OP, LAST_SPARE_OP)),
                         $urandom);
            end
            sent++;
         end
      end
      calm_phase = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tracker.note_request(req_tdata[OPCODE_W-1:0], req_tdata[OPCODE_W +: VALUE_W]);
         end
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_result(rsp_tdata);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < 25) begin
            rsp_stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      req_tvalid <= 1'b0;
      // The last item is noted at the edge just passed, so the pending count is first checked after the next edge.
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
